### rtl/rsi_pkg.sv
// shared constants for the ray / sphere intersection block
package rsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS = 16;
  localparam int RADIUS_RESET = 65536;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd3;

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_ONE = 2'd1;
  localparam logic [1:0] HIT_TWO = 2'd2;

endpackage

### rtl/rsi_ray_if.sv
// ray input channel
interface rsi_ray_if import rsi_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [W-1:0] origin_x;
  logic signed [W-1:0] origin_y;
  logic signed [W-1:0] origin_z;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;

  modport source (output valid, output origin_x, output origin_y, output origin_z,
                  output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input origin_x, input origin_y, input origin_z,
                input dir_x, input dir_y, input dir_z, output ready);
endinterface

### rtl/rsi_hit_if.sv
// intersection result channel
interface rsi_hit_if import rsi_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic [1:0] hit_count;
  logic signed [W-1:0] t_near;
  logic signed [W-1:0] t_far;

  modport source (output valid, output hit_count, output t_near, output t_far, input ready);
  modport sink (input valid, input hit_count, input t_near, input t_far, output ready);
endinterface

### rtl/rsi_cfg_if.sv
// configuration write channel
interface rsi_cfg_if import rsi_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/ray_sphere_intersect.sv
// ray / sphere intersection, fully pipelined quadratic solver
// throughput: one ray per cycle; set by the bit-per-stage square root and
// the two bit-per-stage dividers, each stage stalls only when full and blocked
// reset: clears all stage valid bits, centers to zero, radius to 1.0
module ray_sphere_intersect import rsi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  rsi_ray_if.sink ray,
  rsi_hit_if.source hit,
  rsi_cfg_if.sink cfg
);

  localparam int W = COORD_WIDTH;
  localparam int OW = W + 1;
  localparam int VW = 2 * W + 4;
  localparam int K = VW / 2;
  localparam int HW = VW - K;
  localparam int QW = 2 * VW;
  localparam int SW = VW;
  localparam int TW = QW + 1;
  localparam int NW = VW + 2;
  localparam int MW = NW + FRAC_BITS + 1;
  localparam int S0 = 6;
  localparam int NUMST = S0 + SW;
  localparam int MAGST = NUMST + 1;
  localparam int D0 = MAGST + 1;
  localparam int FIN = D0 + MW;
  localparam int NS = FIN + 1;

  localparam logic [W-2:0] RAD_RST = (W-1)'(RADIUS_RESET);
  localparam logic [MW-1:0] POS_LIM = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [MW-1:0] NEG_LIM = {{(MW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  // config registers
  logic signed [W-1:0] cen_x, cen_y, cen_z;
  logic [W-2:0] rad;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cen_x <= '0;
      cen_y <= '0;
      cen_z <= '0;
      rad <= RAD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CENTER_X: cen_x <= cfg.data;
        REG_CENTER_Y: cen_y <= cfg.data;
        REG_CENTER_Z: cen_z <= cfg.data;
        REG_RADIUS: rad <= cfg.data[W-2:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and stall chain
  logic [NS-1:0] v;
  logic [NS:0] en;

  assign en[NS] = hit.ready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign ray.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= ray.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: offset from center
  logic signed [OW-1:0] o_x, o_y, o_z;
  logic signed [W-1:0] d_x, d_y, d_z;
  logic [W-2:0] rad0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      o_x <= OW'(ray.origin_x) - OW'(cen_x);
      o_y <= OW'(ray.origin_y) - OW'(cen_y);
      o_z <= OW'(ray.origin_z) - OW'(cen_z);
      d_x <= ray.dir_x;
      d_y <= ray.dir_y;
      d_z <= ray.dir_z;
      rad0 <= rad;
    end
  end

  // stage 1: component products
  logic signed [OW+W-1:0] od_x, od_y, od_z;
  logic signed [2*OW-1:0] oo_x, oo_y, oo_z;
  logic signed [2*W-1:0] dd_x, dd_y, dd_z;
  logic [2*W-3:0] rr;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      od_x <= o_x * d_x;
      od_y <= o_y * d_y;
      od_z <= o_z * d_z;
      oo_x <= o_x * o_x;
      oo_y <= o_y * o_y;
      oo_z <= o_z * o_z;
      dd_x <= d_x * d_x;
      dd_y <= d_y * d_y;
      dd_z <= d_z * d_z;
      rr <= rad0 * rad0;
    end
  end

  // stage 2: quadratic coefficients
  logic signed [VW-1:0] a2, h2, c2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a2 <= VW'(dd_x) + VW'(dd_y) + VW'(dd_z);
      h2 <= VW'(od_x) + VW'(od_y) + VW'(od_z);
      c2 <= VW'(oo_x) + VW'(oo_y) + VW'(oo_z) - VW'(rr);
    end
  end

  // stage 3: partial products of h*h and a*c
  logic signed [2*HW-1:0] hh_hh, ac_hh;
  logic signed [HW+K:0] hh_hl, ac_hl, ac_lh;
  logic [2*K-1:0] hh_ll, ac_ll;
  logic signed [VW-1:0] a3, h3;
  logic nz3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hh_hh <= $signed(h2[VW-1:K]) * $signed(h2[VW-1:K]);
      hh_hl <= $signed(h2[VW-1:K]) * $signed({1'b0, h2[K-1:0]});
      hh_ll <= h2[K-1:0] * h2[K-1:0];
      ac_hh <= $signed(a2[VW-1:K]) * $signed(c2[VW-1:K]);
      ac_hl <= $signed(a2[VW-1:K]) * $signed({1'b0, c2[K-1:0]});
      ac_lh <= $signed(c2[VW-1:K]) * $signed({1'b0, a2[K-1:0]});
      ac_ll <= a2[K-1:0] * c2[K-1:0];
      a3 <= a2;
      h3 <= h2;
      nz3 <= (a2 != '0);
    end
  end

  // stage 4: full products
  logic [QW-1:0] hh4, ac4;
  logic signed [VW-1:0] a4, h4;
  logic nz4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hh4 <= (QW'(hh_hh) << (2*K)) + (QW'(hh_hl) << (K+1)) + QW'(hh_ll);
      ac4 <= (QW'(ac_hh) << (2*K)) + ((QW'(ac_hl) + QW'(ac_lh)) << K) + QW'(ac_ll);
      a4 <= a3;
      h4 <= h3;
      nz4 <= nz3;
    end
  end

  // stage 5: discriminant and root count
  logic [QW-1:0] q5;
  logic [1:0] hc5;

  always_comb begin
    q5 = hh4 - ac4;
    if (!nz4 || q5[QW-1]) hc5 = HIT_NONE;
    else if (q5 == '0) hc5 = HIT_ONE;
    else hc5 = HIT_TWO;
  end

  logic [QW-1:0] sq_rem [0:SW];
  logic [SW-1:0] sq_res [0:SW];
  logic signed [VW-1:0] sq_h [0:SW];
  logic [VW-1:0] sq_a [0:SW];
  logic [1:0] sq_hc [0:SW];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sq_rem[0] <= (hc5 == HIT_TWO) ? q5 : '0;
      sq_res[0] <= '0;
      sq_h[0] <= h4;
      sq_a[0] <= a4;
      sq_hc[0] <= hc5;
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    localparam int I = SW - 1 - j;
    logic [TW-1:0] trial;
    logic take;

    always_comb begin
      trial = (TW'(sq_res[j]) << (I+1)) | (TW'(1) << (2*I));
      take = TW'(sq_rem[j]) >= trial;
    end

    always_ff @(posedge clk) begin
      if (en[S0+j]) begin
        sq_rem[j+1] <= take ? QW'(TW'(sq_rem[j]) - trial) : sq_rem[j];
        sq_res[j+1] <= take ? (sq_res[j] | (SW'(1) << I)) : sq_res[j];
        sq_h[j+1] <= sq_h[j];
        sq_a[j+1] <= sq_a[j];
        sq_hc[j+1] <= sq_hc[j];
      end
    end
  end

  // numerators
  logic signed [NW-1:0] n_lo, n_hi;
  logic [VW-1:0] num_a;
  logic [1:0] num_hc;

  always_ff @(posedge clk) begin
    if (en[NUMST]) begin
      n_lo <= -NW'(sq_h[SW]) - NW'(sq_res[SW]);
      n_hi <= -NW'(sq_h[SW]) + NW'(sq_res[SW]);
      num_a <= sq_a[SW];
      num_hc <= sq_hc[SW];
    end
  end

  // dividend magnitudes, biased for floor rounding of negatives
  logic [NW-1:0] abs_lo, abs_hi;
  logic [MW-1:0] bias;

  always_comb begin
    abs_lo = n_lo[NW-1] ? NW'(-n_lo) : NW'(n_lo);
    abs_hi = n_hi[NW-1] ? NW'(-n_hi) : NW'(n_hi);
    bias = MW'(num_a) - MW'(1);
  end

  logic [MW-1:0] dv_m_lo [0:MW];
  logic [MW-1:0] dv_m_hi [0:MW];
  logic [VW-1:0] dv_r_lo [0:MW];
  logic [VW-1:0] dv_r_hi [0:MW];
  logic dv_neg_lo [0:MW];
  logic dv_neg_hi [0:MW];
  logic [VW-1:0] dv_a [0:MW];
  logic [1:0] dv_hc [0:MW];

  always_ff @(posedge clk) begin
    if (en[MAGST]) begin
      dv_m_lo[0] <= (MW'(abs_lo) << FRAC_BITS) + (n_lo[NW-1] ? bias : '0);
      dv_m_hi[0] <= (MW'(abs_hi) << FRAC_BITS) + (n_hi[NW-1] ? bias : '0);
      dv_r_lo[0] <= '0;
      dv_r_hi[0] <= '0;
      dv_neg_lo[0] <= n_lo[NW-1];
      dv_neg_hi[0] <= n_hi[NW-1];
      dv_a[0] <= num_a;
      dv_hc[0] <= num_hc;
    end
  end

  // restoring dividers, one quotient bit per stage
  for (genvar k = 0; k < MW; k++) begin : g_div
    logic [VW:0] r2_lo, r2_hi, df_lo, df_hi;
    logic ge_lo, ge_hi;

    always_comb begin
      r2_lo = {dv_r_lo[k], dv_m_lo[k][MW-1]};
      r2_hi = {dv_r_hi[k], dv_m_hi[k][MW-1]};
      df_lo = r2_lo - {1'b0, dv_a[k]};
      df_hi = r2_hi - {1'b0, dv_a[k]};
      ge_lo = r2_lo >= {1'b0, dv_a[k]};
      ge_hi = r2_hi >= {1'b0, dv_a[k]};
    end

    always_ff @(posedge clk) begin
      if (en[D0+k]) begin
        dv_r_lo[k+1] <= ge_lo ? df_lo[VW-1:0] : r2_lo[VW-1:0];
        dv_r_hi[k+1] <= ge_hi ? df_hi[VW-1:0] : r2_hi[VW-1:0];
        dv_m_lo[k+1] <= {dv_m_lo[k][MW-2:0], ge_lo};
        dv_m_hi[k+1] <= {dv_m_hi[k][MW-2:0], ge_hi};
        dv_neg_lo[k+1] <= dv_neg_lo[k];
        dv_neg_hi[k+1] <= dv_neg_hi[k];
        dv_a[k+1] <= dv_a[k];
        dv_hc[k+1] <= dv_hc[k];
      end
    end
  end

  function automatic logic [W-1:0] sat(input logic [MW-1:0] quo, input logic neg);
    logic [MW-1:0] nq;
    nq = -quo;
    if (!neg) return (quo > POS_LIM) ? {1'b0, {(W-1){1'b1}}} : quo[W-1:0];
    return (quo > NEG_LIM) ? {1'b1, {(W-1){1'b0}}} : nq[W-1:0];
  endfunction

  // output register
  logic [1:0] out_cnt;
  logic [W-1:0] out_near, out_far;

  always_ff @(posedge clk) begin
    if (en[FIN]) begin
      out_cnt <= dv_hc[MW];
      out_near <= (dv_hc[MW] == HIT_NONE) ? '0 : sat(dv_m_lo[MW], dv_neg_lo[MW]);
      out_far <= (dv_hc[MW] == HIT_NONE) ? '0 : sat(dv_m_hi[MW], dv_neg_hi[MW]);
    end
  end

  assign hit.valid = v[FIN];
  assign hit.hit_count = out_cnt;
  assign hit.t_near = out_near;
  assign hit.t_far = out_far;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    hit.valid && hit.hit_count == HIT_NONE |-> hit.t_near == '0 && hit.t_far == '0)
    else $error("miss beat with nonzero roots");
  a_tangent_eq: assert property (@(posedge clk) disable iff (rst)
    hit.valid && hit.hit_count == HIT_ONE |-> hit.t_near == hit.t_far)
    else $error("tangent beat with distinct roots");
  a_order: assert property (@(posedge clk) disable iff (rst)
    hit.valid && hit.hit_count == HIT_TWO |-> hit.t_near <= hit.t_far)
    else $error("near root above far root");
  a_count: assert property (@(posedge clk) disable iff (rst)
    hit.valid |-> hit.hit_count != 2'd3)
    else $error("bad hit count");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    !v[FIN] |-> ray.ready)
    else $error("input stalled with an empty output stage");
`endif

endmodule
